// ----- design/dpa_pkg.sv -----
package dpa_pkg;

  // default table and pipe counts
  localparam int NUM_PLANES_DEF = 16;
  localparam int NUM_PIPES_DEF  = 8;

  // fixed field widths
  localparam int SLOT_W = 4;
  localparam int MASK_W = 8;
  localparam int KIND_W = 2;
  localparam int PIPE_W = 3;

  // at most this many bound planes per request
  localparam int MAX_RESULTS = 16;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // plane kinds
  localparam logic [KIND_W-1:0] KIND_OVERLAY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRIMARY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURSOR  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ALLOC,
    OP_EMPTY
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DED,
    ST_SHR,
    ST_DONE
  } state_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e                op;
    logic               wr_en;
    logic [SLOT_W-1:0]  slot;
    logic [MASK_W-1:0]  mask;
    logic [KIND_W-1:0]  kind;
    logic [MASK_W-1:0]  pbit;
    logic               shared_always;
    logic               shared_if_none;
  } cmd_t;

endpackage

// ----- design/display_plane_allocator.sv -----
// channel    direction  transfer when                 fields
// request    in         start high, busy low          req_type_i entry_index_i pipe_mask_in_i
//                                                     plane_kind_i pipe_index_i
// result     out        result_strobe_o high          plane_slot_o plane_found_o
//                                                     was_dedicated_o last_o
//
// a load goes through the command queue and the load state, and its acknowledge is registered
// an allocation runs one pass over the table per round, with a dedicated round and,
// for overlays and for primaries that bound nothing, a shared round after it;
// the single read port of the plane table paces the scan at one entry a cycle
// reset clears the idle flags, so no plane is available until loaded
// busy rises only when the two-entry command queue is full; results cannot be held off
module display_plane_allocator #(
  parameter int NUM_PLANES = dpa_pkg::NUM_PLANES_DEF,
  parameter int NUM_PIPES  = dpa_pkg::NUM_PIPES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [dpa_pkg::SLOT_W-1:0]  entry_index_i,
  input  logic [dpa_pkg::MASK_W-1:0]  pipe_mask_in_i,
  input  logic [dpa_pkg::KIND_W-1:0]  plane_kind_i,
  input  logic [dpa_pkg::PIPE_W-1:0]  pipe_index_i,
  output logic                        result_strobe_o,
  output logic [dpa_pkg::SLOT_W-1:0]  plane_slot_o,
  output logic                        plane_found_o,
  output logic                        was_dedicated_o,
  output logic                        last_o
);
  import dpa_pkg::*;

  cmd_t front_cmd;   // classified request from the front
  cmd_t head_cmd;    // oldest queued command
  logic push;
  logic q_full;
  logic q_vld;
  logic q_pop;

  // a request transfer pushes straight into the queue
  assign busy = q_full;
  assign push = start && !q_full;

  // front: decode the request, trim the mask, pick the shared-round policy
  dpa_front #(
    .NUM_PLANES (NUM_PLANES),
    .NUM_PIPES  (NUM_PIPES)
  ) u_front (
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .pipe_mask_in_i (pipe_mask_in_i),
    .plane_kind_i   (plane_kind_i),
    .pipe_index_i   (pipe_index_i),
    .cmd_o          (front_cmd)
  );

  // short queue so requests can land while the back end scans
  dpa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (q_pop),
    .full_o (q_full),
    .vld_o  (q_vld),
    .cmd_o  (head_cmd)
  );

  // back: table owner, runs loads and the dedicated and shared scans
  dpa_back #(
    .NUM_PLANES (NUM_PLANES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .res_vld_o   (result_strobe_o),
    .res_slot_o  (plane_slot_o),
    .res_found_o (plane_found_o),
    .res_ded_o   (was_dedicated_o),
    .res_last_o  (last_o)
  );

endmodule

// ----- design/dpa_front.sv -----
module dpa_front #(
  parameter int NUM_PLANES = dpa_pkg::NUM_PLANES_DEF,
  parameter int NUM_PIPES  = dpa_pkg::NUM_PIPES_DEF
) (
  input  logic                        req_type_i,
  input  logic [dpa_pkg::SLOT_W-1:0]  entry_index_i,
  input  logic [dpa_pkg::MASK_W-1:0]  pipe_mask_in_i,
  input  logic [dpa_pkg::KIND_W-1:0]  plane_kind_i,
  input  logic [dpa_pkg::PIPE_W-1:0]  pipe_index_i,
  output dpa_pkg::cmd_t               cmd_o
);
  import dpa_pkg::*;

  // pipe bits the table can hold
  localparam logic [MASK_W-1:0] KeepMask =
    (NUM_PIPES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PIPES) - 1);

  logic slot_ok;
  logic pipe_ok;

  assign slot_ok = int'(entry_index_i) < NUM_PLANES;
  assign pipe_ok = int'(pipe_index_i) < NUM_PIPES;

  always_comb begin
    cmd_o.wr_en          = 1'b0;
    cmd_o.slot           = entry_index_i;
    cmd_o.mask           = pipe_mask_in_i & KeepMask;
    cmd_o.kind           = plane_kind_i;
    cmd_o.pbit           = MASK_W'(1) << pipe_index_i;
    cmd_o.shared_always  = plane_kind_i == KIND_OVERLAY;
    cmd_o.shared_if_none = plane_kind_i == KIND_PRIMARY;
    if (req_type_i == REQ_LOAD) begin
      cmd_o.op    = OP_LOAD;
      cmd_o.wr_en = slot_ok;
    end else if (pipe_ok) begin
      cmd_o.op = OP_ALLOC;
    end else begin
      // pipe outside the table binds nothing
      cmd_o.op = OP_EMPTY;
    end
  end

endmodule

// ----- design/dpa_queue.sv -----
module dpa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dpa_pkg::cmd_t  cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           vld_o,
  output dpa_pkg::cmd_t  cmd_o
);
  import dpa_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o = cnt_q == CntW'(QUEUE_DEPTH);
  assign vld_o  = cnt_q != '0;
  assign cmd_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/dpa_back.sv -----
module dpa_back #(
  parameter int NUM_PLANES = dpa_pkg::NUM_PLANES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_vld_i,
  input  dpa_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  output logic                        res_vld_o,
  output logic [dpa_pkg::SLOT_W-1:0]  res_slot_o,
  output logic                        res_found_o,
  output logic                        res_ded_o,
  output logic                        res_last_o
);
  import dpa_pkg::*;

  localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int CW = $clog2(NUM_PLANES + 1);
  localparam int EW = KIND_W + MASK_W;

  // plane table: kind and mask in a memory, idle flags in flops
  logic [EW-1:0]         ent_mem [NUM_PLANES];
  logic [EW-1:0]         rd_data_q;
  logic [NUM_PLANES-1:0] idle_q;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NCNT_W-1:0] n_q, n_d;
  logic              pend_vld_q, pend_vld_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic              pend_ded_q, pend_ded_d;
  logic              res_vld_q, res_vld_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_found_q, res_found_d;
  logic              res_ded_q, res_ded_d;
  logic              res_last_q, res_last_d;

  logic              rd_en, mem_we, idle_set, idle_clr;
  logic [PW-1:0]     rd_addr, wr_addr, ev_idx;
  logic [MASK_W-1:0] e_mask;
  logic [KIND_W-1:0] e_kind;
  logic              base_hit, hit;

  assign rd_addr = PW'(cnt_q);
  assign wr_addr = PW'(cmd_q.slot);
  assign ev_idx  = PW'(cnt_q - CW'(1));
  assign e_mask  = rd_data_q[MASK_W-1:0];
  assign e_kind  = rd_data_q[EW-1:MASK_W];

  // entry under evaluation was read in the previous cycle
  assign base_hit = (cnt_q != '0) && idle_q[ev_idx] && (e_kind == cmd_q.kind) &&
                    (n_q < NCNT_W'(MAX_RESULTS));

  always_comb begin
    hit = 1'b0;
    case (state_q)
      ST_DED:  hit = base_hit && (e_mask == cmd_q.pbit);
      ST_SHR:  hit = base_hit && (e_mask != cmd_q.pbit) && ((e_mask & cmd_q.pbit) != '0);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    pend_ded_d  = pend_ded_q;
    res_vld_d   = 1'b0;
    res_slot_d  = '0;
    res_found_d = 1'b0;
    res_ded_d   = 1'b0;
    res_last_d  = 1'b0;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    idle_set    = 1'b0;
    idle_clr    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          q_pop_o    = 1'b1;
          cmd_d      = q_cmd_i;
          cnt_d      = '0;
          n_d        = '0;
          pend_vld_d = 1'b0;
          case (q_cmd_i.op)
            OP_LOAD:  state_d = ST_LOAD;
            OP_ALLOC: state_d = ST_DED;
            default:  state_d = ST_DONE;
          endcase
        end
      end

      ST_LOAD: begin
        mem_we     = cmd_q.wr_en;
        idle_set   = cmd_q.wr_en;
        res_vld_d  = 1'b1;
        res_slot_d = cmd_q.slot;
        res_last_d = 1'b1;
        state_d    = ST_IDLE;
      end

      ST_DED, ST_SHR: begin
        if (hit) begin
          idle_clr    = 1'b1;
          n_d         = n_q + NCNT_W'(1);
          // the held result is not the last one, send it
          if (pend_vld_q) begin
            res_vld_d   = 1'b1;
            res_slot_d  = pend_slot_q;
            res_found_d = 1'b1;
            res_ded_d   = pend_ded_q;
          end
          pend_vld_d  = 1'b1;
          pend_slot_d = SLOT_W'(ev_idx);
          pend_ded_d  = state_q == ST_DED;
        end
        if (cnt_q != CW'(NUM_PLANES)) begin
          rd_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end else begin
          cnt_d = '0;
          if (state_q == ST_DED &&
              (cmd_q.shared_always || (cmd_q.shared_if_none && n_d == '0))) begin
            state_d = ST_SHR;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_vld_d  = 1'b1;
        res_last_d = 1'b1;
        if (pend_vld_q) begin
          res_slot_d  = pend_slot_q;
          res_found_d = 1'b1;
          res_ded_d   = pend_ded_q;
        end
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      pend_vld_q  <= 1'b0;
      res_vld_q   <= 1'b0;
      idle_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      pend_vld_q  <= pend_vld_d;
      res_vld_q   <= res_vld_d;
      if (idle_set) begin
        idle_q[wr_addr] <= 1'b1;
      end
      if (idle_clr) begin
        idle_q[ev_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pend_slot_q <= pend_slot_d;
    pend_ded_q  <= pend_ded_d;
    res_slot_q  <= res_slot_d;
    res_found_q <= res_found_d;
    res_ded_q   <= res_ded_d;
    res_last_q  <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ent_mem[wr_addr] <= {cmd_q.kind, cmd_q.mask};
    end
    if (rd_en) begin
      rd_data_q <= ent_mem[rd_addr];
    end
  end

  assign res_vld_o   = res_vld_q;
  assign res_slot_o  = res_slot_q;
  assign res_found_o = res_found_q;
  assign res_ded_o   = res_ded_q;
  assign res_last_o  = res_last_q;

endmodule

// ----- tb/sv/display_plane_allocator_tb.sv -----
`timescale 1ns / 100ps

module display_plane_allocator_tb;
  import dpa_pkg::*;

  // kind three has no name in the package; it is stored and matched like any other
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam logic [MASK_W-1:0] PIPE_MASK_ALL = MASK_W'((1 << NUM_PIPES_DEF) - 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 2 * NUM_PLANES_DEF + 8;
  localparam int CALM_TAIL   = 40;

  // one request transfer plus how the sender paces it
  typedef struct {
    logic              req_type;
    logic [SLOT_W-1:0] entry_index;
    logic [MASK_W-1:0] pipe_mask;
    logic [KIND_W-1:0] kind;
    logic [PIPE_W-1:0] pipe;
    int                idle_before;
    bit                drain_before;
  } plane_req_t;

  // one result transfer: a bound plane, a load acknowledge or a miss
  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic              dedicated;
    logic              last;
  } grant_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic              req_type_i     = 1'b0;
  logic [SLOT_W-1:0] entry_index_i  = '0;
  logic [MASK_W-1:0] pipe_mask_in_i = '0;
  logic [KIND_W-1:0] plane_kind_i   = '0;
  logic [PIPE_W-1:0] pipe_index_i   = '0;
  logic              result_strobe_o;
  logic [SLOT_W-1:0] plane_slot_o;
  logic              plane_found_o;
  logic              was_dedicated_o;
  logic              last_o;

  // shadow copy of the plane table
  logic [MASK_W-1:0] plane_mask_tbl [NUM_PLANES_DEF];
  logic [KIND_W-1:0] plane_kind_tbl [NUM_PLANES_DEF];
  logic              plane_idle_tbl [NUM_PLANES_DEF];

  plane_req_t pending_reqs[$];
  grant_t     expected_grants[$];
  logic       item_taken  = 1'b0;
  int         hold_cycles = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  display_plane_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .pipe_mask_in_i  (pipe_mask_in_i),
    .plane_kind_i    (plane_kind_i),
    .pipe_index_i    (pipe_index_i),
    .result_strobe_o (result_strobe_o),
    .plane_slot_o    (plane_slot_o),
    .plane_found_o   (plane_found_o),
    .was_dedicated_o (was_dedicated_o),
    .last_o          (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic void add_grant(input logic [SLOT_W-1:0] slot, input logic found,
                                    input logic dedicated, input logic last);
    grant_t g;
    g.slot      = slot;
    g.found     = found;
    g.dedicated = dedicated;
    g.last      = last;
    expected_grants = {expected_grants, g};
  endfunction

  // works out the results of one accepted request and updates the shadow table
  function automatic void predict_grants(input plane_req_t rq);
    logic [MASK_W-1:0] pbit;
    int                bound;
    bound = 0;
    if (rq.req_type == REQ_LOAD) begin
      if (int'(rq.entry_index) < NUM_PLANES_DEF) begin
        plane_mask_tbl[rq.entry_index] = rq.pipe_mask & PIPE_MASK_ALL;
        plane_kind_tbl[rq.entry_index] = rq.kind;
        plane_idle_tbl[rq.entry_index] = 1'b1;
      end
      add_grant(rq.entry_index, 1'b0, 1'b0, 1'b1);
    end else if (int'(rq.pipe) >= NUM_PIPES_DEF) begin
      add_grant('0, 1'b0, 1'b0, 1'b1);
    end else begin
      pbit = MASK_W'(1) << rq.pipe;
      // dedicated round: mask is exactly this pipe
      for (int i = 0; i < NUM_PLANES_DEF; i++) begin
        if (bound < MAX_RESULTS && plane_idle_tbl[i] && plane_kind_tbl[i] == rq.kind &&
            plane_mask_tbl[i] == pbit) begin
          plane_idle_tbl[i] = 1'b0;
          add_grant(SLOT_W'(i), 1'b1, 1'b1, 1'b0);
          bound++;
        end
      end
      // shared round: overlays always, primaries only as a fallback
      if (rq.kind == KIND_OVERLAY || (rq.kind == KIND_PRIMARY && bound == 0)) begin
        for (int i = 0; i < NUM_PLANES_DEF; i++) begin
          if (bound < MAX_RESULTS && plane_idle_tbl[i] && plane_kind_tbl[i] == rq.kind &&
              plane_mask_tbl[i] != pbit && (plane_mask_tbl[i] & pbit) != '0) begin
            plane_idle_tbl[i] = 1'b0;
            add_grant(SLOT_W'(i), 1'b1, 1'b0, 1'b0);
            bound++;
          end
        end
      end
      if (bound == 0) add_grant('0, 1'b0, 1'b0, 1'b1);
      else expected_grants[expected_grants.size() - 1].last = 1'b1;
    end
  endfunction

  // unused fields of each request carry random bits all the same
  function automatic void queue_load(input int unsigned slot, input logic [MASK_W-1:0] mask,
                                     input logic [KIND_W-1:0] kind);
    plane_req_t rq;
    rq.req_type     = REQ_LOAD;
    rq.entry_index  = SLOT_W'(slot);
    rq.pipe_mask    = mask;
    rq.kind         = kind;
    rq.pipe         = PIPE_W'($urandom);
    rq.idle_before  = 0;
    rq.drain_before = 1'b0;
    pending_reqs = {pending_reqs, rq};
  endfunction

  function automatic void queue_alloc(input int unsigned pipe, input logic [KIND_W-1:0] kind,
                                      input bit drain);
    plane_req_t rq;
    rq.req_type     = REQ_ALLOC;
    rq.entry_index  = SLOT_W'($urandom);
    rq.pipe_mask    = MASK_W'($urandom);
    rq.kind         = kind;
    rq.pipe         = PIPE_W'(pipe);
    rq.idle_before  = 0;
    rq.drain_before = drain;
    pending_reqs = {pending_reqs, rq};
  endfunction

  // a mask aimed at pipe p: dedicated, shared, unrelated or some random single pipe
  function automatic logic [MASK_W-1:0] pick_mask(input int unsigned p);
    logic [MASK_W-1:0] pbit;
    pbit = MASK_W'(1) << p;
    case ($urandom_range(0, 3))
      0:       return pbit;
      1:       return pbit | MASK_W'($urandom);
      2:       return MASK_W'($urandom);
      default: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
    endcase
  endfunction

  // driver: presents the next request at the falling edge once the last one transferred
  always @(negedge clk_i) begin : drive_proc
    logic       drive_start;
    plane_req_t nxt;
    drive_start = start;
    if (!rst_ni) begin
      drive_start = 1'b0;
      hold_cycles <= 0;
    end else if (!start || item_taken) begin
      drive_start = 1'b0;
      if (pending_reqs.size() != 0) begin
        nxt = pending_reqs[0];
        // hold off for the idle burst, and for a full drain where asked
        if (hold_cycles >= nxt.idle_before &&
            (!nxt.drain_before || expected_grants.size() == 0)) begin
          void'(pending_reqs.pop_front());
          req_type_i     <= nxt.req_type;
          entry_index_i  <= nxt.entry_index;
          pipe_mask_in_i <= nxt.pipe_mask;
          plane_kind_i   <= nxt.kind;
          pipe_index_i   <= nxt.pipe;
          drive_start = 1'b1;
          hold_cycles <= 0;
        end else begin
          hold_cycles <= hold_cycles + 1;
        end
      end
    end
    start <= drive_start;
  end

  // monitor: checks results first, then predicts the request transferred at this edge
  always @(posedge clk_i) begin : watch_proc
    grant_t     want;
    plane_req_t seen;
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      if (result_strobe_o) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("result slot %0d with nothing expected", plane_slot_o));
        end else begin
          want = expected_grants.pop_front();
          if (plane_slot_o !== want.slot || plane_found_o !== want.found ||
              was_dedicated_o !== want.dedicated || last_o !== want.last)
            report_mismatch($sformatf(
              "got slot %0d found %b dedicated %b last %b, expected %0d %b %b %b",
              plane_slot_o, plane_found_o, was_dedicated_o, last_o,
              want.slot, want.found, want.dedicated, want.last));
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        seen.req_type     = req_type_i;
        seen.entry_index  = entry_index_i;
        seen.pipe_mask    = pipe_mask_in_i;
        seen.kind         = plane_kind_i;
        seen.pipe         = pipe_index_i;
        seen.idle_before  = 0;
        seen.drain_before = 1'b0;
        predict_grants(seen);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : main_proc
    int unsigned       seq;
    int unsigned       p;
    int                calm;
    logic [KIND_W-1:0] k;

    for (int i = 0; i < NUM_PLANES_DEF; i++) begin
      plane_mask_tbl[i] = '0;
      plane_kind_tbl[i] = KIND_OVERLAY;
      plane_idle_tbl[i] = 1'b0;
    end

    // directed: empty table, then one plane of each flavor
    queue_alloc(0, KIND_OVERLAY, 1'b0);
    queue_load(0, 8'h01, KIND_PRIMARY);
    queue_load(15, 8'hFF, KIND_OVERLAY);
    queue_load(5, 8'h01, KIND_OVERLAY);
    queue_load(3, 8'h03, KIND_PRIMARY);
    queue_load(7, 8'h80, KIND_CURSOR);
    queue_load(8, 8'h81, KIND_CURSOR);
    queue_load(9, 8'h04, KIND_RESERVED);
    queue_load(11, 8'h05, KIND_RESERVED);
    queue_load(10, 8'h00, KIND_OVERLAY);
    // primary: dedicated only, shared skipped
    queue_alloc(0, KIND_PRIMARY, 1'b1);
    // primary fallback to shared
    queue_alloc(1, KIND_PRIMARY, 1'b0);
    // overlay: dedicated then shared in one run
    queue_alloc(0, KIND_OVERLAY, 1'b0);
    // cursor never takes a shared plane
    queue_alloc(7, KIND_CURSOR, 1'b0);
    queue_alloc(0, KIND_CURSOR, 1'b0);
    // kind three runs the dedicated round only
    queue_alloc(2, KIND_RESERVED, 1'b0);
    queue_alloc(0, KIND_RESERVED, 1'b0);
    // all overlays for pipe seven are gone
    queue_alloc(7, KIND_OVERLAY, 1'b0);
    // second primary request falls back once the dedicated one is bound
    queue_load(4, 8'h7E, KIND_PRIMARY);
    queue_load(12, 8'h40, KIND_PRIMARY);
    queue_alloc(6, KIND_PRIMARY, 1'b1);
    queue_alloc(6, KIND_PRIMARY, 1'b0);

    // random part, mostly load bursts followed by allocations that can hit them
    while (pending_reqs.size() < 262) begin
      seq = $urandom_range(0, 9);
      if (seq <= 5) begin
        p = $urandom_range(0, NUM_PIPES_DEF - 1);
        k = ($urandom_range(0, 7) == 0) ? KIND_RESERVED : KIND_W'($urandom_range(0, 2));
        repeat ($urandom_range(1, 5))
          queue_load($urandom_range(0, NUM_PLANES_DEF - 1), pick_mask(p),
                     ($urandom_range(0, 3) == 0) ? KIND_W'($urandom) : k);
        repeat ($urandom_range(1, 2)) queue_alloc(p, k, $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 2) == 0)
          queue_alloc($urandom_range(0, NUM_PIPES_DEF - 1), KIND_W'($urandom), 1'b0);
      end else if (seq == 6) begin
        // refill the whole table around one pipe; overlays can bind all sixteen
        p = $urandom_range(0, NUM_PIPES_DEF - 1);
        k = ($urandom_range(0, 3) == 0) ? KIND_W'($urandom) : KIND_OVERLAY;
        for (int s = 0; s < NUM_PLANES_DEF; s++)
          queue_load(s, ($urandom_range(0, 4) == 0) ? pick_mask(p)
                                                     : (MASK_W'($urandom) | (MASK_W'(1) << p)),
                     k);
        queue_alloc(p, k, $urandom_range(0, 1) == 1);
      end else if (seq <= 8) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0)
            queue_load($urandom_range(0, NUM_PLANES_DEF - 1), MASK_W'($urandom),
                       KIND_W'($urandom));
          else
            queue_alloc($urandom_range(0, NUM_PIPES_DEF - 1), KIND_W'($urandom), 1'b0);
        end
      end else begin
        queue_alloc($urandom_range(0, NUM_PIPES_DEF - 1), KIND_W'($urandom), 1'b1);
      end
    end

    // sender idle bursts, with calm stretches and none near the end
    calm = 0;
    foreach (pending_reqs[i]) begin
      if (i >= pending_reqs.size() - CALM_TAIL) begin
        pending_reqs[i].idle_before = 0;
      end else if (calm > 0) begin
        pending_reqs[i].idle_before = 0;
        calm--;
      end else if ($urandom_range(0, 9) == 0) begin
        pending_reqs[i].idle_before = 0;
        calm = $urandom_range(10, 30);
      end else begin
        pending_reqs[i].idle_before = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || start) @(negedge clk_i);
    while (expected_grants.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_grants.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_grants.size()));

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
